// ===== rtl/core/absb_pkg.sv =====
// Shared constants, types and register codes of the alpha blend sprite blitter.
package absb_pkg;

	localparam int FRAME_COLUMN_PIXELS = 240;
	localparam int FRAME_COLUMNS       = 400;

	localparam int COL_W     = 9;
	localparam int ROW_W     = 8;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CHAN_W    = 8;
	localparam int ADDR_W    = 19;
	localparam int PIX_IDX_W = $clog2(FRAME_COLUMN_PIXELS * FRAME_COLUMNS);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE      = 8'd255;
	localparam logic [CHAN_W-1:0] ALPHA_TRANSPARENT = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_COLUMN = 2'd0,
		CFG_START_ROW    = 2'd1,
		CFG_RECT_COLUMNS = 2'd2,
		CFG_RECT_ROWS    = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_KEEP,
		KIND_COPY,
		KIND_BLEND
	} pix_kind_t;

	typedef struct packed {
		pix_kind_t               kind;
		logic [CHAN_W-1:0]       alpha;
		logic [CHAN_W-1:0]       src_blue;
		logic [CHAN_W-1:0]       src_green;
		logic [CHAN_W-1:0]       src_red;
		logic [CHAN_W-1:0]       old_blue;
		logic [CHAN_W-1:0]       old_green;
		logic [CHAN_W-1:0]       old_red;
		logic [PIX_IDX_W-1:0]    pix_idx;
		logic                    outside;
		logic                    last;
	} blit_job_t;

endpackage

// ===== rtl/core/absb_front.sv =====
// Front end: registers, rectangle walk, pixel classification and position.
module absb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [absb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [absb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7*absb_pkg::CHAN_W-1:0]     in_data,
	input  logic                              queue_full,
	output logic                              push,
	output absb_pkg::blit_job_t               job
);

	logic [absb_pkg::COL_W-1:0] start_column_q;
	logic [absb_pkg::ROW_W-1:0] start_row_q;
	logic [absb_pkg::COL_W-1:0] rect_columns_q;
	logic [absb_pkg::ROW_W-1:0] rect_rows_q;
	logic [absb_pkg::COL_W-1:0] column_count_q;
	logic [absb_pkg::ROW_W-1:0] row_count_q;

	logic [absb_pkg::COL_W:0]   col;
	logic [absb_pkg::ROW_W:0]   row;
	logic                       outside;
	logic                       row_end;
	logic                       col_end;
	logic [absb_pkg::CHAN_W-1:0] alpha;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	assign col = {1'b0, start_column_q} + {1'b0, column_count_q};
	assign row = {1'b0, start_row_q} + {1'b0, row_count_q};
	assign outside = (col >= (absb_pkg::COL_W+1)'(absb_pkg::FRAME_COLUMNS)) ||
		(row >= (absb_pkg::ROW_W+1)'(absb_pkg::FRAME_COLUMN_PIXELS));

	// a size of zero behaves as one
	assign row_end = ({1'b0, row_count_q} + 1'b1) >= {1'b0, rect_rows_q};
	assign col_end = ({1'b0, column_count_q} + 1'b1) >= {1'b0, rect_columns_q};

	assign alpha = in_data[7:0];

	always_comb begin
		job.alpha     = alpha;
		job.src_blue  = in_data[15:8];
		job.src_green = in_data[23:16];
		job.src_red   = in_data[31:24];
		job.old_blue  = in_data[39:32];
		job.old_green = in_data[47:40];
		job.old_red   = in_data[55:48];
		job.outside   = outside;
		job.last      = row_end && col_end;
		if (outside) begin
			job.pix_idx = '0;
		end else begin
			job.pix_idx = absb_pkg::PIX_IDX_W'(col) *
				absb_pkg::PIX_IDX_W'(absb_pkg::FRAME_COLUMN_PIXELS) +
				absb_pkg::PIX_IDX_W'(row);
		end
		if (alpha == absb_pkg::ALPHA_OPAQUE) begin
			job.kind = absb_pkg::KIND_COPY;
		end else if (alpha == absb_pkg::ALPHA_TRANSPARENT) begin
			job.kind = absb_pkg::KIND_KEEP;
		end else begin
			job.kind = absb_pkg::KIND_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_column_q <= '0;
			start_row_q    <= '0;
			rect_columns_q <= absb_pkg::COL_W'(1);
			rect_rows_q    <= absb_pkg::ROW_W'(1);
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (cfg_wr_en) begin
			// any write restarts the walk
			column_count_q <= '0;
			row_count_q    <= '0;
			case (absb_pkg::cfg_index_t'(cfg_index))
				absb_pkg::CFG_START_COLUMN: start_column_q <= cfg_data;
				absb_pkg::CFG_START_ROW:    start_row_q    <= cfg_data[absb_pkg::ROW_W-1:0];
				absb_pkg::CFG_RECT_COLUMNS: rect_columns_q <= cfg_data;
				absb_pkg::CFG_RECT_ROWS:    rect_rows_q    <= cfg_data[absb_pkg::ROW_W-1:0];
				default: ;
			endcase
		end else if (push) begin
			if (row_end) begin
				row_count_q <= '0;
				if (col_end) begin
					column_count_q <= '0;
				end else begin
					column_count_q <= column_count_q + 1'b1;
				end
			end else begin
				row_count_q <= row_count_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/absb_queue.sv =====
// Short job queue between front and back ends.
module absb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  absb_pkg::blit_job_t  push_job,
	input  logic                 pop,
	output absb_pkg::blit_job_t  head_job,
	output logic                 full,
	output logic                 empty
);

	absb_pkg::blit_job_t            entries_q [absb_pkg::QUEUE_DEPTH];
	logic [absb_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [absb_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [absb_pkg::QPTR_W:0]      count_q;

	assign full     = count_q == (absb_pkg::QPTR_W+1)'(absb_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/absb_back.sv =====
// Back end: channel blend, byte address and output register.
module absb_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  absb_pkg::blit_job_t                head_job,
	input  logic                               queue_empty,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [absb_pkg::ADDR_W-1:0]        byte_address_q,
	output logic [absb_pkg::CHAN_W-1:0]        new_blue_q,
	output logic [absb_pkg::CHAN_W-1:0]        new_green_q,
	output logic [absb_pkg::CHAN_W-1:0]        new_red_q,
	output logic                               write_enable_q,
	output logic                               out_of_frame_q,
	output logic                               last_pixel_q
);

	logic                          out_valid_q;
	logic [absb_pkg::CHAN_W-1:0]   inv_alpha;
	logic [2*absb_pkg::CHAN_W-1:0] mix_blue;
	logic [2*absb_pkg::CHAN_W-1:0] mix_green;
	logic [2*absb_pkg::CHAN_W-1:0] mix_red;
	logic [absb_pkg::ADDR_W-1:0]   idx_wide;
	logic [absb_pkg::CHAN_W-1:0]   nb;
	logic [absb_pkg::CHAN_W-1:0]   ng;
	logic [absb_pkg::CHAN_W-1:0]   nr;

	assign out_valid = out_valid_q;
	assign pop       = !queue_empty && (!out_valid_q || out_ready);

	assign inv_alpha = absb_pkg::ALPHA_OPAQUE - head_job.alpha;
	// sum stays below 2^16, keep the top byte
	assign mix_blue  = 16'(head_job.old_blue) * 16'(inv_alpha) +
		16'(head_job.src_blue) * 16'(head_job.alpha);
	assign mix_green = 16'(head_job.old_green) * 16'(inv_alpha) +
		16'(head_job.src_green) * 16'(head_job.alpha);
	assign mix_red   = 16'(head_job.old_red) * 16'(inv_alpha) +
		16'(head_job.src_red) * 16'(head_job.alpha);

	assign idx_wide = absb_pkg::ADDR_W'(head_job.pix_idx);

	always_comb begin
		case (head_job.kind)
			absb_pkg::KIND_COPY: begin
				nb = head_job.src_blue;
				ng = head_job.src_green;
				nr = head_job.src_red;
			end
			absb_pkg::KIND_BLEND: begin
				nb = mix_blue[15:8];
				ng = mix_green[15:8];
				nr = mix_red[15:8];
			end
			default: begin
				nb = head_job.old_blue;
				ng = head_job.old_green;
				nr = head_job.old_red;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_address_q <= (idx_wide << 1) + idx_wide;
			new_blue_q     <= nb;
			new_green_q    <= ng;
			new_red_q      <= nr;
			write_enable_q <= (head_job.kind != absb_pkg::KIND_KEEP) && !head_job.outside;
			out_of_frame_q <= head_job.outside;
			last_pixel_q   <= head_job.last;
		end
	end

endmodule

// ===== rtl/core/alpha_blend_sprite_blit.sv =====
// Top level of the alpha blend sprite blitter.
//
// Input stream: one beat per source pixel, taken column by column, each column
// top to bottom, together with the frame pixel now stored at that place.
// Output stream: one beat per input beat, in order, with the byte address in a
// column-major frame of 3-byte pixels, the pixel to write and its flags.
// The front end walks the rectangle and classifies the pixel (copy, keep, blend)
// in the accept cycle and pushes a job into a four-entry queue; the back end
// blends the channels and loads the output register.
// An accepted input beat is held in a queue entry and then in the output register.
// Throughput: one beat per cycle while the output side is ready, set by the
// front end and output register; the queue soaks up short output stalls.
// When the receiver stalls, the output beat is held and the queue fills; input
// ready drops only once the queue is full.
// Reset empties the queue, clears output valid and sets the rectangle to one
// pixel at the frame origin. The user makes register writes only while idle;
// the block does not enforce it. A write restarts the walk at the first pixel.
module alpha_blend_sprite_blit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [absb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [absb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// src_alpha, src_blue, src_green, src_red, old_blue, old_green, old_red
	input  logic [55:0]                       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// byte_address, new_blue, new_green, new_red, zero fill
	output logic [47:0]                       m_axis_tdata,
	// write_enable, out_of_frame
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);

	absb_pkg::blit_job_t               push_job;
	absb_pkg::blit_job_t               head_job;
	logic                              push;
	logic                              pop;
	logic                              queue_full;
	logic                              queue_empty;
	logic [absb_pkg::ADDR_W-1:0]       byte_address;
	logic [absb_pkg::CHAN_W-1:0]       new_blue;
	logic [absb_pkg::CHAN_W-1:0]       new_green;
	logic [absb_pkg::CHAN_W-1:0]       new_red;
	logic                              write_enable;
	logic                              out_of_frame;
	logic                              last_pixel;

	absb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	absb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	absb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_job       (head_job),
		.queue_empty    (queue_empty),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.byte_address_q (byte_address),
		.new_blue_q     (new_blue),
		.new_green_q    (new_green),
		.new_red_q      (new_red),
		.write_enable_q (write_enable),
		.out_of_frame_q (out_of_frame),
		.last_pixel_q   (last_pixel)
	);

	assign m_axis_tdata = {5'd0, new_red, new_green, new_blue, byte_address};
	assign m_axis_tuser = {out_of_frame, write_enable};
	assign m_axis_tlast = last_pixel;

`ifndef SYNTHESIS
	a_no_write_outside: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("write flagged for a pixel outside the frame");

	a_outside_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[18:0] == 19'd0)
		else $error("non-zero address on a pixel outside the frame");

	a_addr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[18:0] <= 19'(3 * (absb_pkg::FRAME_COLUMNS *
		absb_pkg::FRAME_COLUMN_PIXELS - 1)))
		else $error("byte address beyond the frame");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		queue_full && !pop |=> !push || pop)
		else $error("job pushed into a full queue");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the alpha blend sprite blitter: directed and random walks.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [absb_pkg::CHAN_W-1:0] alpha;
		logic [absb_pkg::CHAN_W-1:0] src_blue;
		logic [absb_pkg::CHAN_W-1:0] src_green;
		logic [absb_pkg::CHAN_W-1:0] src_red;
		logic [absb_pkg::CHAN_W-1:0] old_blue;
		logic [absb_pkg::CHAN_W-1:0] old_green;
		logic [absb_pkg::CHAN_W-1:0] old_red;
	} pixel_t;

	typedef struct packed {
		logic [absb_pkg::ADDR_W-1:0] byte_address;
		logic                        write_enable;
		logic [absb_pkg::CHAN_W-1:0] new_blue;
		logic [absb_pkg::CHAN_W-1:0] new_green;
		logic [absb_pkg::CHAN_W-1:0] new_red;
		logic                        out_of_frame;
		logic                        last_pixel;
	} blit_write_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [absb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [absb_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [55:0]                    s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [47:0]                    m_axis_tdata;
	logic [1:0]                     m_axis_tuser;
	logic                           m_axis_tlast;

	alpha_blend_sprite_blit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Blitter registers and walk position as the bench sees them
	logic [absb_pkg::COL_W-1:0] first_column = '0;
	logic [absb_pkg::ROW_W-1:0] first_row    = '0;
	logic [absb_pkg::COL_W-1:0] width_cols   = 9'd1;
	logic [absb_pkg::ROW_W-1:0] height_rows  = 8'd1;
	int                         walk_column  = 0;
	int                         walk_row     = 0;

	blit_write_t pending_writes[$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          pixels_sent   = 0;
	int          writes_seen   = 0;
	int          settings_used = 0;
	int          outside_count = 0;
	int          clear_count   = 0;
	int          rect_ends     = 0;
	int          mismatches    = 0;

	function automatic logic [absb_pkg::CHAN_W-1:0] mix_channel(
			logic [absb_pkg::CHAN_W-1:0] oldv, logic [absb_pkg::CHAN_W-1:0] srcv,
			logic [absb_pkg::CHAN_W-1:0] a);
		int v;
		v = (int'(oldv) * (255 - int'(a)) + int'(srcv) * int'(a)) >> 8;
		return v[absb_pkg::CHAN_W-1:0];
	endfunction

	// Work out the frame write for one pixel and advance the walk
	function automatic blit_write_t blit_pixel(pixel_t px);
		blit_write_t w;
		int col, row, offset;
		bit row_end, col_end;
		col = int'(first_column) + walk_column;
		row = int'(first_row) + walk_row;
		w.out_of_frame = (col >= absb_pkg::FRAME_COLUMNS) ||
			(row >= absb_pkg::FRAME_COLUMN_PIXELS);
		offset = (col * absb_pkg::FRAME_COLUMN_PIXELS + row) * 3;
		w.byte_address = w.out_of_frame ? '0 : offset[absb_pkg::ADDR_W-1:0];
		if (px.alpha == absb_pkg::ALPHA_OPAQUE) begin
			w.new_blue = px.src_blue;
			w.new_green = px.src_green;
			w.new_red = px.src_red;
			w.write_enable = 1'b1;
		end else if (px.alpha == absb_pkg::ALPHA_TRANSPARENT) begin
			w.new_blue = px.old_blue;
			w.new_green = px.old_green;
			w.new_red = px.old_red;
			w.write_enable = 1'b0;
		end else begin
			w.new_blue = mix_channel(px.old_blue, px.src_blue, px.alpha);
			w.new_green = mix_channel(px.old_green, px.src_green, px.alpha);
			w.new_red = mix_channel(px.old_red, px.src_red, px.alpha);
			w.write_enable = 1'b1;
		end
		if (w.out_of_frame)
			w.write_enable = 1'b0;
		row_end = (walk_row + 1) >= int'(height_rows);
		col_end = (walk_column + 1) >= int'(width_cols);
		if (row_end) begin
			walk_row = 0;
			walk_column = col_end ? 0 : walk_column + 1;
		end else begin
			walk_row = walk_row + 1;
		end
		w.last_pixel = row_end && col_end;
		return w;
	endfunction

	task automatic note_failure(string what, blit_write_t want, blit_write_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("ERROR %s at %0t: want addr=%0d we=%0b bgr=%02h/%02h/%02h oof=%0b last=%0b",
				what, $realtime,
				want.byte_address, want.write_enable, want.new_blue, want.new_green,
				want.new_red, want.out_of_frame, want.last_pixel);
			$display("      got addr=%0d we=%0b bgr=%02h/%02h/%02h oof=%0b last=%0b",
				got.byte_address, got.write_enable, got.new_blue, got.new_green,
				got.new_red, got.out_of_frame, got.last_pixel);
		end
	endtask

	blit_write_t seen_write;
	blit_write_t due_write;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_write.byte_address = m_axis_tdata[18:0];
			seen_write.new_blue     = m_axis_tdata[26:19];
			seen_write.new_green    = m_axis_tdata[34:27];
			seen_write.new_red      = m_axis_tdata[42:35];
			seen_write.write_enable = m_axis_tuser[0];
			seen_write.out_of_frame = m_axis_tuser[1];
			seen_write.last_pixel   = m_axis_tlast;
			writes_seen++;
			if (pending_writes.size() == 0) begin
				note_failure("unexpected beat", '0, seen_write);
			end else begin
				due_write = pending_writes.pop_front();
				if (seen_write.byte_address !== due_write.byte_address ||
						seen_write.write_enable !== due_write.write_enable ||
						seen_write.new_blue !== due_write.new_blue ||
						seen_write.new_green !== due_write.new_green ||
						seen_write.new_red !== due_write.new_red ||
						seen_write.out_of_frame !== due_write.out_of_frame ||
						seen_write.last_pixel !== due_write.last_pixel)
					note_failure("field mismatch", due_write, seen_write);
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_pixel(pixel_t px);
		blit_write_t w;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {px.old_red, px.old_green, px.old_blue,
			px.src_red, px.src_green, px.src_blue, px.alpha};
		do @(posedge clk); while (!s_axis_tready);
		w = blit_pixel(px);
		pending_writes.push_back(w);
		pixels_sent++;
		outside_count += w.out_of_frame;
		clear_count += (px.alpha == absb_pkg::ALPHA_TRANSPARENT);
		rect_ends += w.last_pixel;
	endtask

	// Hold the input side until every write has come out and the pipe is empty
	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(absb_pkg::cfg_index_t idx, logic [absb_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			absb_pkg::CFG_START_COLUMN: first_column = val[absb_pkg::COL_W-1:0];
			absb_pkg::CFG_START_ROW:    first_row = val[absb_pkg::ROW_W-1:0];
			absb_pkg::CFG_RECT_COLUMNS: width_cols = val[absb_pkg::COL_W-1:0];
			absb_pkg::CFG_RECT_ROWS:    height_rows = val[absb_pkg::ROW_W-1:0];
			default:                    ;
		endcase
		walk_column = 0;
		walk_row = 0;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_rectangle(logic [absb_pkg::CFG_W-1:0] col0,
			logic [absb_pkg::CFG_W-1:0] row0, logic [absb_pkg::CFG_W-1:0] cols,
			logic [absb_pkg::CFG_W-1:0] rows);
		drain();
		write_reg(absb_pkg::CFG_START_COLUMN, col0);
		write_reg(absb_pkg::CFG_START_ROW, row0);
		write_reg(absb_pkg::CFG_RECT_COLUMNS, cols);
		write_reg(absb_pkg::CFG_RECT_ROWS, rows);
		settings_used++;
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		px = 56'({$urandom, $urandom});
		case ($urandom_range(7))
			0, 1:    px.alpha = absb_pkg::ALPHA_TRANSPARENT;
			2, 3:    px.alpha = absb_pkg::ALPHA_OPAQUE;
			4:       px.alpha = $urandom_range(1) ? 8'd1 : 8'd254;
			default: px.alpha = 8'($urandom_range(255));
		endcase
		return px;
	endfunction

	function automatic pixel_t make_pixel(logic [7:0] a, logic [7:0] s, logic [7:0] o);
		return {a, s, s, s, o, o, o};
	endfunction

	// Reset rectangle is one pixel at the frame origin
	task automatic test_pixel_kinds;
		send_pixel(make_pixel(absb_pkg::ALPHA_OPAQUE, 8'hFF, 8'h00));
		send_pixel(make_pixel(absb_pkg::ALPHA_TRANSPARENT, 8'hFF, 8'hA5));
		send_pixel(make_pixel(8'd1, 8'hFF, 8'h00));
		send_pixel(make_pixel(8'd254, 8'h00, 8'hFF));
		send_pixel(make_pixel(8'd128, 8'hFF, 8'hFF));
		send_pixel({8'd127, 8'h12, 8'h34, 8'h56, 8'hED, 8'hCB, 8'hA9});
	endtask

	// Last in-frame corner, then positions past the right and bottom edges, then wrap
	task automatic test_frame_edge;
		set_rectangle(9'd399, 9'd239, 9'd2, 9'd2);
		repeat (5) send_pixel(make_pixel(absb_pkg::ALPHA_OPAQUE, 8'h5A, 8'h11));
	endtask

	// Zero width or height walks as one
	task automatic test_zero_size;
		set_rectangle(9'd10, 9'd20, 9'd0, 9'd0);
		repeat (2) send_pixel(make_pixel(8'd200, 8'hFF, 8'h00));
		set_rectangle(9'd0, 9'd0, 9'd3, 9'd0);
		repeat (4) send_pixel(make_pixel(absb_pkg::ALPHA_OPAQUE, 8'h81, 8'h7E));
	endtask

	// Widest settings and start far outside the frame; row register ignores bit 8
	task automatic test_oversize;
		set_rectangle(9'd511, 9'h1FF, 9'd511, 9'h1FF);
		repeat (3) send_pixel(make_pixel(8'd64, 8'hFF, 8'h00));
		set_rectangle(9'd0, 9'h100, 9'd400, 9'd240);
		repeat (3) send_pixel(make_pixel(absb_pkg::ALPHA_OPAQUE, 8'h00, 8'hFF));
	endtask

	task automatic test_random_walks(int item_count, int send_pct, int recv_pct);
		int goal, count, area, cols, rows, col0, row0;
		goal = pixels_sent + item_count;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (pixels_sent < goal) begin
			cols = $urandom_range(1, 6);
			rows = $urandom_range(1, 8);
			col0 = $urandom_range(0, 399);
			row0 = $urandom_range(0, 239);
			if ($urandom_range(2) == 0) begin
				col0 = $urandom_range(394, 399);
				row0 = $urandom_range(232, 239);
			end
			case ($urandom_range(9))
				6: if ($urandom_range(1)) cols = 0; else rows = 0;
				7: begin
					col0 = $urandom_range(0, 511);
					row0 = $urandom_range(240, 255);
				end
				8: begin
					cols = $urandom_range(1, 2);
					rows = $urandom_range(200, 255);
				end
				9: begin
					cols = $urandom_range(400, 511);
					rows = $urandom_range(240, 255);
					col0 = $urandom_range(0, 511);
				end
				default: ;
			endcase
			set_rectangle(col0[8:0], {1'($urandom_range(1)), row0[7:0]},
				cols[8:0], {1'($urandom_range(1)), rows[7:0]});
			area = (cols == 0 ? 1 : cols) * (rows == 0 ? 1 : rows);
			if (area > 600)
				count = $urandom_range(20, 60);
			else if ($urandom_range(4) == 0)
				count = $urandom_range(1, area);  // broken off mid-walk
			else
				count = area * $urandom_range(1, 3);
			repeat (count) send_pixel(random_pixel());
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_pixel_kinds();
		test_frame_edge();
		test_zero_size();
		test_oversize();
		test_random_walks(650, 33, 56);
		test_random_walks(650, 56, 33);
		test_random_walks(650, 0, 0);
		drain();
		repeat (4) @(posedge clk);
		while (pending_writes.size() != 0)
			note_failure("missing beat", pending_writes.pop_front(), '0);
		$display("covered %0d pixels in %0d rectangle settings, %0d beats out",
			pixels_sent, settings_used, writes_seen);
		$display("%0d outside the frame, %0d transparent, %0d rectangle ends, %0d failures",
			outside_count, clear_count, rect_ends, mismatches);
		if (mismatches == 0)
			$display("alpha_blend_sprite_blit: match");
		else
			$display("alpha_blend_sprite_blit: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d beats outstanding", pending_writes.size());
		$display("alpha_blend_sprite_blit: mismatch");
		$finish;
	end

endmodule
